/* hw/rtl/iau_pkg.sv */
// ----------------------------------------------------------------------------
// iau_pkg
// Shared widths, command codes, payload types and helpers of the interval
// arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iau_pkg;

    // fixed-point format
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int CMD_W     = 4;

    // divider: magnitude of (x << FRAC_BITS) and of the quotient
    localparam int QUO_W     = DATA_W + FRAC_BITS;
    // square root: root digits and radicand width
    localparam int SQ_ROOT_W = (DATA_W - 1 + FRAC_BITS + 1) / 2;
    localparam int SQ_RAD_W  = 2 * SQ_ROOT_W;
    // stages from the request register up to the arithmetic result register
    localparam int CORE_LAT  = QUO_W + 2;
    // delay that lines the square root up with the divider
    localparam int SQ_PAD    = CORE_LAT - 1 - SQ_ROOT_W;

    // full product and the internal working width
    localparam int MUL_W     = 2 * DATA_W;
    localparam int PROD_SH_W = MUL_W - FRAC_BITS + 1;
    localparam int WIDE_W    = (QUO_W + 2 > PROD_SH_W) ? QUO_W + 2 : PROD_SH_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_NEG       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SQUARE    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SQRT      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_UNION     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_INTERSECT = 4'd8;
    localparam logic [CMD_W-1:0] CMD_EQUAL     = 4'd9;
    localparam logic [CMD_W-1:0] CMD_LESS      = 4'd10;
    localparam logic [CMD_W-1:0] CMD_COPY      = 4'd11;

    // configuration register indexes
    localparam logic CFG_MAX_VALUE = 1'b0;
    localparam logic CFG_MIN_VALUE = 1'b1;

    typedef logic signed [WIDE_W-1:0] wide_t;

    // request payload
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] a_low;
        logic signed [DATA_W-1:0] a_high;
        logic signed [DATA_W-1:0] b_low;
        logic signed [DATA_W-1:0] b_high;
    } req_t;

    // result payload
    typedef struct packed {
        logic signed [DATA_W-1:0] res_low;
        logic signed [DATA_W-1:0] res_high;
        logic                     empty_res;
        logic                     error;
    } res_t;

    // divider result
    typedef struct packed {
        wide_t quo;
        logic  by_zero;
        logic  num_neg;
    } quo_t;

    function automatic wide_t min_w(input wide_t x, input wide_t y);
        return (x < y) ? x : y;
    endfunction

    function automatic wide_t max_w(input wide_t x, input wide_t y);
        return (x > y) ? x : y;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/interval_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// interval_arithmetic_unit_top
// Interval arithmetic on signed Q16.16 bounds with saturation to programmable
// limits.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle unless the result side stalls, and
// returns one result per request, in order. The pipeline depth is set by the
// 48-stage restoring divider (one quotient bit per stage); every command walks
// the same pipeline, so results never reorder. A stall on the result side
// freezes the whole pipeline and is passed straight back as request stall. The user must
// write max_value and min_value only while the pipeline is empty; the block does not enforce it.
`default_nettype none

module interval_arithmetic_unit_top import iau_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire req_t                     req,
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output res_t                          res,
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_index,
    input  wire logic signed [DATA_W-1:0] cfg_data
);

    localparam wide_t ONE_W = wide_t'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] max_value_reg;
    logic signed [DATA_W-1:0] min_value_reg;

    logic                     en;
    logic                     vld_reg  [CORE_LAT];
    req_t                     side_reg [CORE_LAT];
    logic signed [MUL_W-1:0]  prod_reg [4];

    quo_t                     quo      [4];
    logic [SQ_ROOT_W-1:0]     root_lo;
    logic [SQ_ROOT_W-1:0]     root_hi;

    req_t                     ms;
    logic signed [DATA_W-1:0] mul_b0;
    logic signed [DATA_W-1:0] mul_b3;

    req_t                     s;
    wide_t                    maxw;
    wide_t                    minw;
    wide_t                    mv [4];
    wide_t                    qv [4];
    wide_t                    fv [4];
    wide_t                    fmin;
    wide_t                    fmax;
    wide_t                    al;
    wide_t                    ah;
    wide_t                    bl;
    wide_t                    bh;
    wide_t                    lo_next;
    wide_t                    hi_next;
    logic                     sat_next;
    logic                     empty_next;
    logic                     err_next;

    logic                     a_vld_reg;
    wide_t                    a_lo_reg;
    wide_t                    a_hi_reg;
    logic                     a_sat_reg;
    logic                     a_empty_reg;
    logic                     a_err_reg;

    wide_t                    lo_sat;
    wide_t                    hi_sat;
    logic                     res_valid_reg;
    res_t                     res_reg;

    // pipeline moves unless a finished result is held
    assign en        = !(res_valid_reg && res_stall);
    assign req_stall = !en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= 32'sh7FFF_FFFF;
            min_value_reg <= 32'sh8000_0000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_VALUE: max_value_reg <= cfg_data;
                CFG_MIN_VALUE: min_value_reg <= cfg_data;
            endcase
        end
    end

    // valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORE_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            a_vld_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= req_valid;
            for (int i = 1; i < CORE_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            a_vld_reg     <= vld_reg[CORE_LAT-1];
            res_valid_reg <= a_vld_reg;
        end
    end

    // request operands travel alongside the long units
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= req;
            for (int i = 1; i < CORE_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // four endpoint quotients
    iau_div u_div_ll (.clk(clk), .en(en), .num(req.a_low),  .den(req.b_low),  .quo(quo[0]));
    iau_div u_div_lh (.clk(clk), .en(en), .num(req.a_low),  .den(req.b_high), .quo(quo[1]));
    iau_div u_div_hl (.clk(clk), .en(en), .num(req.a_high), .den(req.b_low),  .quo(quo[2]));
    iau_div u_div_hh (.clk(clk), .en(en), .num(req.a_high), .den(req.b_high), .quo(quo[3]));

    // endpoint square roots
    iau_sqrt u_sqrt_lo (.clk(clk), .en(en), .x(req.a_low),  .root(root_lo));
    iau_sqrt u_sqrt_hi (.clk(clk), .en(en), .x(req.a_high), .root(root_hi));

    // endpoint products, taken one stage before the results line up
    assign ms     = side_reg[CORE_LAT-2];
    assign mul_b0 = (ms.cmd == CMD_SQUARE) ? ms.a_low  : ms.b_low;
    assign mul_b3 = (ms.cmd == CMD_SQUARE) ? ms.a_high : ms.b_high;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= MUL_W'(ms.a_low)  * MUL_W'(mul_b0);
            prod_reg[1] <= MUL_W'(ms.a_low)  * MUL_W'(ms.b_high);
            prod_reg[2] <= MUL_W'(ms.a_high) * MUL_W'(ms.b_low);
            prod_reg[3] <= MUL_W'(ms.a_high) * MUL_W'(mul_b3);
        end
    end

    // endpoint candidates for mul and div
    assign s    = side_reg[CORE_LAT-1];
    assign maxw = wide_t'(max_value_reg);
    assign minw = wide_t'(min_value_reg);
    assign al   = wide_t'(s.a_low);
    assign ah   = wide_t'(s.a_high);
    assign bl   = wide_t'(s.b_low);
    assign bh   = wide_t'(s.b_high);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mv[i] = wide_t'(prod_reg[i] >>> FRAC_BITS);
            qv[i] = quo[i].by_zero ? (quo[i].num_neg ? minw : maxw) : quo[i].quo;
            fv[i] = (s.cmd == CMD_DIV) ? qv[i] : mv[i];
        end
    end

    assign fmin = min_w(min_w(fv[0], fv[1]), min_w(fv[2], fv[3]));
    assign fmax = max_w(max_w(fv[0], fv[1]), max_w(fv[2], fv[3]));

    // per-command result bounds and flags
    always_comb
    begin
        lo_next    = '0;
        hi_next    = '0;
        sat_next   = 1'b1;
        empty_next = 1'b0;
        err_next   = 1'b0;
        unique case (s.cmd)
            CMD_ADD:
            begin
                lo_next = al + bl;
                hi_next = ah + bh;
            end
            CMD_SUB:
            begin
                lo_next = al - bh;
                hi_next = ah - bl;
            end
            CMD_MUL:
            begin
                lo_next = fmin;
                hi_next = fmax;
            end
            CMD_DIV:
            begin
                if (bl <= 0 && bh >= 0)
                begin
                    // divisor contains zero
                    priority if ((al < 0 && ah > 0) || (bl < 0 && bh > 0))
                    begin
                        lo_next = minw;
                        hi_next = maxw;
                    end
                    else if (bl == 0 && bh == 0)
                    begin
                        priority if (al >= 0)
                        begin
                            lo_next = maxw;
                            hi_next = maxw;
                        end
                        else if (ah <= 0)
                        begin
                            lo_next = minw;
                            hi_next = minw;
                        end
                        else
                        begin
                            lo_next  = minw;
                            hi_next  = maxw;
                            err_next = 1'b1;
                        end
                    end
                    else if (al >= 0 && bl == 0)
                    begin
                        lo_next = qv[1];
                        hi_next = maxw;
                    end
                    else if (ah <= 0 && bl == 0)
                    begin
                        lo_next = minw;
                        hi_next = qv[3];
                    end
                    else if (al >= 0 && bh == 0)
                    begin
                        lo_next = minw;
                        hi_next = qv[0];
                    end
                    else if (ah <= 0 && bh == 0)
                    begin
                        lo_next = qv[2];
                        hi_next = maxw;
                    end
                    else
                    begin
                        lo_next  = minw;
                        hi_next  = maxw;
                        err_next = 1'b1;
                    end
                end
                else
                begin
                    lo_next = fmin;
                    hi_next = fmax;
                end
            end
            CMD_NEG:
            begin
                lo_next = -ah;
                hi_next = -al;
            end
            CMD_SQUARE:
            begin
                lo_next = (al < 0 && ah > 0) ? '0 : min_w(mv[0], mv[3]);
                hi_next = max_w(mv[0], mv[3]);
            end
            CMD_SQRT:
            begin
                if (ah < 0)
                begin
                    err_next = 1'b1;
                    sat_next = 1'b0;
                end
                else
                begin
                    lo_next = wide_t'({{(WIDE_W-SQ_ROOT_W){1'b0}}, root_lo});
                    hi_next = wide_t'({{(WIDE_W-SQ_ROOT_W){1'b0}}, root_hi});
                end
            end
            CMD_UNION:
            begin
                sat_next = 1'b0;
                lo_next  = min_w(al, bl);
                hi_next  = max_w(ah, bh);
            end
            CMD_INTERSECT:
            begin
                sat_next = 1'b0;
                if (max_w(al, bl) > min_w(ah, bh))
                begin
                    empty_next = 1'b1;
                end
                else
                begin
                    lo_next = max_w(al, bl);
                    hi_next = min_w(ah, bh);
                end
            end
            CMD_EQUAL:
            begin
                sat_next = 1'b0;
                priority if (ah < bl || al > bh)
                begin
                    lo_next = '0;
                    hi_next = '0;
                end
                else if (al == ah && ah == bl && bl == bh)
                begin
                    lo_next = ONE_W;
                    hi_next = ONE_W;
                end
                else
                begin
                    lo_next = '0;
                    hi_next = ONE_W;
                end
            end
            CMD_LESS:
            begin
                sat_next = 1'b0;
                priority if (al >= bh)
                begin
                    lo_next = '0;
                    hi_next = '0;
                end
                else if (ah < bl)
                begin
                    lo_next = ONE_W;
                    hi_next = ONE_W;
                end
                else
                begin
                    lo_next = '0;
                    hi_next = ONE_W;
                end
            end
            CMD_COPY:
            begin
                sat_next = 1'b0;
                lo_next  = al;
                hi_next  = ah;
            end
            default:
            begin
                sat_next = 1'b0;
            end
        endcase
    end

    // bound selection stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_lo_reg    <= lo_next;
            a_hi_reg    <= hi_next;
            a_sat_reg   <= sat_next;
            a_empty_reg <= empty_next;
            a_err_reg   <= err_next;
        end
    end

    // saturation to the programmed limits
    always_comb
    begin
        priority if (a_lo_reg > maxw)
            lo_sat = maxw;
        else if (a_lo_reg < minw)
            lo_sat = minw;
        else
            lo_sat = a_lo_reg;
        priority if (a_hi_reg > maxw)
            hi_sat = maxw;
        else if (a_hi_reg < minw)
            hi_sat = minw;
        else
            hi_sat = a_hi_reg;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.res_low   <= a_sat_reg ? lo_sat[DATA_W-1:0] : a_lo_reg[DATA_W-1:0];
            res_reg.res_high  <= a_sat_reg ? hi_sat[DATA_W-1:0] : a_hi_reg[DATA_W-1:0];
            res_reg.empty_res <= a_empty_reg;
            res_reg.error     <= a_err_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* hw/rtl/iau_div.sv */
// ----------------------------------------------------------------------------
// iau_div
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module iau_div import iau_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [DATA_W-1:0] num,
    input  wire logic signed [DATA_W-1:0] den,
    output quo_t                          quo
);

    logic [QUO_W-1:0]  num_reg  [QUO_W+1];
    logic [DATA_W-1:0] den_reg  [QUO_W+1];
    logic [DATA_W-1:0] rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  q_reg    [QUO_W+1];
    logic              neg_reg  [QUO_W+1];
    logic              zero_reg [QUO_W+1];
    logic              nneg_reg [QUO_W+1];

    logic [DATA_W:0]   trial    [QUO_W];
    logic [DATA_W:0]   diff     [QUO_W];
    logic              ge       [QUO_W];
    logic [DATA_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0]  q_next   [QUO_W];

    logic [DATA_W-1:0] num_abs;
    logic [DATA_W-1:0] den_abs;
    logic [WIDE_W-1:0] q_ext;
    quo_t              quo_reg;

    // operand magnitudes
    assign num_abs = num[DATA_W-1] ? (~num + 1'b1) : num;
    assign den_abs = den[DATA_W-1] ? (~den + 1'b1) : den;

    // one quotient bit per stage
    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            trial[s]    = {rem_reg[s], num_reg[s][QUO_W-1]};
            diff[s]     = trial[s] - {1'b0, den_reg[s]};
            ge[s]       = (trial[s] >= {1'b0, den_reg[s]});
            rem_next[s] = ge[s] ? diff[s][DATA_W-1:0] : trial[s][DATA_W-1:0];
            q_next[s]   = {q_reg[s][QUO_W-2:0], ge[s]};
        end
    end

    assign q_ext = {{(WIDE_W-QUO_W){1'b0}}, q_reg[QUO_W]};

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= QUO_W'(num_abs) << FRAC_BITS;
            den_reg[0]  <= den_abs;
            rem_reg[0]  <= '0;
            q_reg[0]    <= '0;
            neg_reg[0]  <= num[DATA_W-1] ^ den[DATA_W-1];
            zero_reg[0] <= (den == '0);
            nneg_reg[0] <= num[DATA_W-1];
            for (int s = 0; s < QUO_W; s++)
            begin
                num_reg[s+1]  <= num_reg[s] << 1;
                den_reg[s+1]  <= den_reg[s];
                rem_reg[s+1]  <= rem_next[s];
                q_reg[s+1]    <= q_next[s];
                neg_reg[s+1]  <= neg_reg[s];
                zero_reg[s+1] <= zero_reg[s];
                nneg_reg[s+1] <= nneg_reg[s];
            end
            quo_reg.quo     <= neg_reg[QUO_W] ? wide_t'(-q_ext) : wide_t'(q_ext);
            quo_reg.by_zero <= zero_reg[QUO_W];
            quo_reg.num_neg <= nneg_reg[QUO_W];
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

/* hw/rtl/iau_sqrt.sv */
// ----------------------------------------------------------------------------
// iau_sqrt
// Pipelined digit-by-digit floor square root of (x << FRAC_BITS), zero for
// x <= 0, delayed to line up with the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module iau_sqrt import iau_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [DATA_W-1:0] x,
    output logic [SQ_ROOT_W-1:0]          root
);

    logic [SQ_RAD_W-1:0]    rad_reg  [SQ_ROOT_W+1];
    logic [SQ_ROOT_W+1:0]   rem_reg  [SQ_ROOT_W+1];
    logic [SQ_ROOT_W-1:0]   root_reg [SQ_ROOT_W+1];
    logic [SQ_ROOT_W-1:0]   pad_reg  [SQ_PAD];

    logic [SQ_ROOT_W+3:0]   rem_w     [SQ_ROOT_W];
    logic [SQ_ROOT_W+3:0]   trial     [SQ_ROOT_W];
    logic [SQ_ROOT_W+3:0]   diff      [SQ_ROOT_W];
    logic                   ge        [SQ_ROOT_W];
    logic [SQ_ROOT_W+1:0]   rem_next  [SQ_ROOT_W];
    logic [SQ_ROOT_W-1:0]   root_next [SQ_ROOT_W];

    // one root bit per stage, two radicand bits consumed
    always_comb
    begin
        for (int s = 0; s < SQ_ROOT_W; s++)
        begin
            rem_w[s]     = {rem_reg[s], rad_reg[s][SQ_RAD_W-1 -: 2]};
            trial[s]     = {2'b00, root_reg[s], 2'b01};
            diff[s]      = rem_w[s] - trial[s];
            ge[s]        = (rem_w[s] >= trial[s]);
            rem_next[s]  = ge[s] ? diff[s][SQ_ROOT_W+1:0] : rem_w[s][SQ_ROOT_W+1:0];
            root_next[s] = {root_reg[s][SQ_ROOT_W-2:0], ge[s]};
        end
    end

    // stage registers and alignment delay
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= (x > 0) ? (SQ_RAD_W'(x[DATA_W-2:0]) << FRAC_BITS) : '0;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int s = 0; s < SQ_ROOT_W; s++)
            begin
                rad_reg[s+1]  <= rad_reg[s] << 2;
                rem_reg[s+1]  <= rem_next[s];
                root_reg[s+1] <= root_next[s];
            end
            pad_reg[0] <= root_reg[SQ_ROOT_W];
            for (int p = 1; p < SQ_PAD; p++)
            begin
                pad_reg[p] <= pad_reg[p-1];
            end
        end
    end

    assign root = pad_reg[SQ_PAD-1];

endmodule

`default_nettype wire

/* bench/tb_interval_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// tb_interval_arithmetic_unit_top
// Self-checking bench for the interval arithmetic unit: directed corner
// requests and random traffic under random idling on both sides, with every
// result checked in order against a local predictor of the fixed-point math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_interval_arithmetic_unit_top;
    import iau_pkg::*;

    // saturation limits, request math and the in-order queue of expected results
    class interval_scoreboard;
        longint upper_lim;
        longint lower_lim;
        res_t   pending[$];
        int     errors;
        int     checked;

        function void set_limits(longint up, longint dn);
            upper_lim = up;
            lower_lim = dn;
        endfunction

        function longint clamp(longint x);
            if (x > upper_lim) return upper_lim;
            if (x < lower_lim) return lower_lim;
            return x;
        endfunction

        function longint fx_mul(longint x, longint y);
            longint p;
            p = x * y;
            return p >>> FRAC_BITS;
        endfunction

        function longint fx_div(longint x, longint y);
            if (y == 0) return (x >= 0) ? upper_lim : lower_lim;
            return (x * (longint'(1) << FRAC_BITS)) / y;
        endfunction

        function longint fx_sqrt(longint x);
            longint unsigned n;
            longint unsigned r;
            longint unsigned b;
            if (x <= 0) return 0;
            n = longint'(x) << FRAC_BITS;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        function longint min4(longint p, longint q, longint r, longint s);
            longint m;
            m = p;
            if (q < m) m = q;
            if (r < m) m = r;
            if (s < m) m = s;
            return m;
        endfunction

        function longint max4(longint p, longint q, longint r, longint s);
            longint m;
            m = p;
            if (q > m) m = q;
            if (r > m) m = r;
            if (s > m) m = s;
            return m;
        endfunction

        // note an accepted request and queue its expected result
        function void note_request(req_t q);
            longint al, ah, bl, bh, lo, hi, one;
            logic   emp, err, clip;
            res_t   r;
            al = q.a_low; ah = q.a_high; bl = q.b_low; bh = q.b_high;
            one = longint'(1) << FRAC_BITS;
            lo = 0; hi = 0; emp = 0; err = 0; clip = 1;
            case (q.cmd)
                CMD_ADD: begin lo = al + bl; hi = ah + bh; end
                CMD_SUB: begin lo = al - bh; hi = ah - bl; end
                CMD_MUL: begin
                    lo = min4(fx_mul(al, bl), fx_mul(al, bh), fx_mul(ah, bl), fx_mul(ah, bh));
                    hi = max4(fx_mul(al, bl), fx_mul(al, bh), fx_mul(ah, bl), fx_mul(ah, bh));
                end
                CMD_DIV: begin
                    if (bl <= 0 && bh >= 0) begin
                        if ((al < 0 && ah > 0) || (bl < 0 && bh > 0)) begin
                            lo = lower_lim; hi = upper_lim;
                        end
                        else if (bl == 0 && bh == 0) begin
                            if (al >= 0) begin lo = upper_lim; hi = upper_lim; end
                            else if (ah <= 0) begin lo = lower_lim; hi = lower_lim; end
                            else begin lo = lower_lim; hi = upper_lim; err = 1; end
                        end
                        else if (al >= 0 && bl == 0) begin
                            lo = fx_div(al, bh); hi = upper_lim;
                        end
                        else if (ah <= 0 && bl == 0) begin
                            lo = lower_lim; hi = fx_div(ah, bh);
                        end
                        else if (al >= 0 && bh == 0) begin
                            lo = lower_lim; hi = fx_div(al, bl);
                        end
                        else if (ah <= 0 && bh == 0) begin
                            lo = fx_div(ah, bl); hi = upper_lim;
                        end
                        else begin
                            lo = lower_lim; hi = upper_lim; err = 1;
                        end
                    end
                    else begin
                        lo = min4(fx_div(al, bl), fx_div(al, bh), fx_div(ah, bl), fx_div(ah, bh));
                        hi = max4(fx_div(al, bl), fx_div(al, bh), fx_div(ah, bl), fx_div(ah, bh));
                    end
                end
                CMD_NEG: begin lo = -ah; hi = -al; end
                CMD_SQUARE: begin
                    lo = (al < 0 && ah > 0) ? 0 :
                         ((fx_mul(al, al) < fx_mul(ah, ah)) ? fx_mul(al, al) : fx_mul(ah, ah));
                    hi = (fx_mul(al, al) > fx_mul(ah, ah)) ? fx_mul(al, al) : fx_mul(ah, ah);
                end
                CMD_SQRT: begin
                    if (ah < 0) begin err = 1; clip = 0; end
                    else begin
                        lo = (al < 0) ? 0 : fx_sqrt(al);
                        hi = fx_sqrt(ah);
                    end
                end
                CMD_UNION: begin
                    clip = 0;
                    lo = (al < bl) ? al : bl;
                    hi = (ah > bh) ? ah : bh;
                end
                CMD_INTERSECT: begin
                    clip = 0;
                    lo = (al > bl) ? al : bl;
                    hi = (ah < bh) ? ah : bh;
                    if (lo > hi) begin emp = 1; lo = 0; hi = 0; end
                end
                CMD_EQUAL: begin
                    clip = 0;
                    if (ah < bl || al > bh) begin lo = 0; hi = 0; end
                    else if (al == ah && ah == bl && bl == bh) begin lo = one; hi = one; end
                    else begin lo = 0; hi = one; end
                end
                CMD_LESS: begin
                    clip = 0;
                    if (al >= bh) begin lo = 0; hi = 0; end
                    else if (ah < bl) begin lo = one; hi = one; end
                    else begin lo = 0; hi = one; end
                end
                CMD_COPY: begin clip = 0; lo = al; hi = ah; end
                default: clip = 0;
            endcase
            if (clip) begin
                lo = clamp(lo);
                hi = clamp(hi);
            end
            r.res_low   = lo[DATA_W-1:0];
            r.res_high  = hi[DATA_W-1:0];
            r.empty_res = emp;
            r.error     = err;
            pending.insert(pending.size(), r);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, got %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.res_low !== want.res_low) begin
                $display("%0t: res_low expected %h actual %h", $time, want.res_low, got.res_low);
                errors++;
            end
            if (got.res_high !== want.res_high) begin
                $display("%0t: res_high expected %h actual %h", $time, want.res_high,
                         got.res_high);
                errors++;
            end
            if (got.empty_res !== want.empty_res) begin
                $display("%0t: empty_res expected %b actual %b", $time, want.empty_res,
                         got.empty_res);
                errors++;
            end
            if (got.error !== want.error) begin
                $display("%0t: error expected %b actual %b", $time, want.error, got.error);
                errors++;
            end
        endfunction
    endclass

    localparam int PIPE_LAT  = 52;
    localparam int CYCLE_CAP = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    req_t                     req;
    logic                     res_valid;
    logic                     res_stall;
    res_t                     res;
    logic                     cfg_write;
    logic                     cfg_index;
    logic signed [DATA_W-1:0] cfg_data;

    interval_scoreboard sb;
    int  cycle_count;
    bit  calm_phase;
    int  sent;

    interval_arithmetic_unit_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: check and stall in random bursts
    initial
    begin
        int hold;
        hold = 0;
        res_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                sb.check_result(res);
            if (hold > 0) begin
                hold--;
                res_stall <= 1'b1;
            end
            else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(0, 13);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // drive one register write; the caller drops the write enable
    task automatic write_limit(logic idx, logic signed [DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // new limits only once the pipeline has drained
    task automatic set_limits(logic signed [DATA_W-1:0] up, logic signed [DATA_W-1:0] dn);
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        write_limit(CFG_MAX_VALUE, up);
        write_limit(CFG_MIN_VALUE, dn);
        cfg_write <= 1'b0;
        sb.set_limits(up, dn);
    endtask

    // present one request, idle first at random, hold until accepted
    task automatic send_request(req_t q);
        int gap;
        if (!calm_phase && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= q;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(q);
        sent++;
    endtask

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) << 16;
            3: return $urandom_range(0, 8) - 4;
            default: return $urandom();
        endcase
    endfunction

    function automatic req_t rand_request();
        req_t q;
        logic [31:0] t;
        q.cmd    = ($urandom_range(0, 19) == 0) ? CMD_W'($urandom_range(12, 15))
                                                : CMD_W'($urandom_range(0, 11));
        q.a_low  = rand_bound();
        q.a_high = rand_bound();
        q.b_low  = rand_bound();
        q.b_high = rand_bound();
        // mostly well-formed intervals, some reversed
        if ($urandom_range(0, 4) != 0 && q.a_low > q.a_high) begin
            t = q.a_low; q.a_low = q.a_high; q.a_high = t;
        end
        if ($urandom_range(0, 4) != 0 && q.b_low > q.b_high) begin
            t = q.b_low; q.b_low = q.b_high; q.b_high = t;
        end
        // zero-touching divisors for the division rules
        if (q.cmd == CMD_DIV && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1)) q.b_low = 0;
            else q.b_high = 0;
        end
        if (q.cmd == CMD_EQUAL && $urandom_range(0, 3) == 0) begin
            q.a_high = q.a_low; q.b_low = q.a_low; q.b_high = q.a_low;
        end
        return q;
    endfunction

    function automatic req_t make_req(logic [CMD_W-1:0] c, int al, int ah, int bl, int bh);
        req_t q;
        q.cmd = c; q.a_low = al; q.a_high = ah; q.b_low = bl; q.b_high = bh;
        return q;
    endfunction

    task automatic directed_set();
        send_request(make_req(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        send_request(make_req(CMD_SUB, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(make_req(CMD_MUL, -3 <<< 16, 2 <<< 16, -5 <<< 16, 32'h7FFF_FFFF));
        send_request(make_req(CMD_MUL, -1, -1, 1, 1));
        send_request(make_req(CMD_DIV, 1 <<< 16, 4 <<< 16, 2 <<< 16, 3 <<< 16));
        send_request(make_req(CMD_DIV, -1 <<< 16, 1 <<< 16, 0, 1 <<< 16));
        send_request(make_req(CMD_DIV, 1 <<< 16, 2 <<< 16, 0, 0));
        send_request(make_req(CMD_DIV, -2 <<< 16, -1 <<< 16, 0, 0));
        send_request(make_req(CMD_DIV, 1 <<< 16, 2 <<< 16, 0, 4 <<< 16));
        send_request(make_req(CMD_DIV, -2 <<< 16, 0, 0, 4 <<< 16));
        send_request(make_req(CMD_DIV, 3 <<< 16, 5 <<< 16, -4 <<< 16, 0));
        send_request(make_req(CMD_DIV, -5 <<< 16, -3 <<< 16, -4 <<< 16, 0));
        send_request(make_req(CMD_DIV, 7 <<< 16, -2 <<< 16, 5 <<< 16, 0));
        send_request(make_req(CMD_NEG, 32'h8000_0000, 32'h8000_0000, 0, 0));
        send_request(make_req(CMD_SQUARE, -3 <<< 16, 2 <<< 16, 0, 0));
        send_request(make_req(CMD_SQRT, -4 <<< 16, 32'h7FFF_FFFF, 0, 0));
        send_request(make_req(CMD_SQRT, 0, -1, 0, 0));
        send_request(make_req(CMD_UNION, 1, 5, -2, 3));
        send_request(make_req(CMD_INTERSECT, 1, 2, 5, 9));
        send_request(make_req(CMD_INTERSECT, 1, 7, 5, 9));
        send_request(make_req(CMD_EQUAL, 3, 3, 3, 3));
        send_request(make_req(CMD_EQUAL, 1, 2, 5, 9));
        send_request(make_req(CMD_LESS, 1, 2, 5, 9));
        send_request(make_req(CMD_LESS, 1, 7, 5, 9));
        send_request(make_req(CMD_COPY, -9, 9, 1, 1));
        send_request(make_req(4'd13, -1, -1, -1, -1));
    endtask

    // main sequence
    initial
    begin
        int wait_cycles;
        sb = new();
        sb.set_limits(64'sd2147483647, -64'sd2147483648);
        cycle_count = 0;
        calm_phase  = 0;
        sent        = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_MAX_VALUE;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_set();
        repeat (200) send_request(rand_request());
        // tight limits around a few units
        set_limits(32'sd5 <<< 16, -32'sd3 <<< 16);
        directed_set();
        repeat (200) send_request(rand_request());
        // extreme and inverted-sign limits
        set_limits(32'sh8000_0000, 32'sh7FFF_FFFF);
        repeat (100) send_request(rand_request());
        set_limits(32'sh7FFF_FFFF, 32'sh8000_0000);
        repeat (100) send_request(rand_request());
        calm_phase = 1;
        repeat (200) send_request(rand_request());
        req_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("Sent %0d requests over four limit settings, checked %0d results.",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/iau_pkg.sv
hw/rtl/iau_div.sv
hw/rtl/iau_sqrt.sv
hw/rtl/interval_arithmetic_unit_top.sv
bench/tb_interval_arithmetic_unit_top.sv
